[rtl/mer_pkg.sv]
// Shared types and constants for the midpoint ellipse rasterizer.
// Holds the controller/datapath command and status structs and all codes.
// No dependencies.
package mer_pkg;

  // Default coordinate width and the fixed result coordinate width
  localparam int COORD_BITS_DEF = 10;
  localparam int OUT_W          = 12;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Y = 3'd3;

  // Walk phase
  typedef enum logic [1:0] {
    PH_DONE = 2'd0,
    PH_R1   = 2'd1,
    PH_R2   = 2'd2
  } phase_t;

  // Datapath register operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD_START,
    OP_R1_STEP,
    OP_R2_STEP,
    OP_DEC1,
    OP_DEC2,
    OP_SET_R1,
    OP_SET_DONE
  } op_t;

  // Multiply selection: operands and where the product goes
  typedef enum logic [2:0] {
    MS_RXRX,
    MS_RYRY,
    MS_RX2RY,
    MS_AA,
    MS_RY2P,
    MS_BB,
    MS_RX2P,
    MS_RX2RY2
  } mul_sel_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RXRX,
    S_RYRY,
    S_RX2RY,
    S_DEC1,
    S_CHK,
    S_AA,
    S_RY2P,
    S_BB,
    S_RX2P,
    S_RX2RY2,
    S_DEC2,
    S_EMIT
  } state_t;

  typedef struct packed {
    op_t      op;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     emit;
    logic     emit_nil;
  } cmd_t;

  typedef struct packed {
    phase_t phase;
    logic   slope_lt;
    logic   y_pos;
    logic   mul_done;
  } sts_t;

endpackage

[rtl/mer_mul.sv]
// Shift-and-add serial multiplier, one multiplier bit per cycle.
// Stops as soon as the remaining multiplier bits are all zero.
// No dependencies.
module mer_mul #(
  parameter int A_W = 48,
  parameter int B_W = 24
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  logic [A_W-1:0] a_in,
  input  logic [B_W-1:0] b_in,
  output logic           done,
  output logic [A_W-1:0] prod
);

  logic           run_r, run_nxt;
  logic [A_W-1:0] a_r, a_nxt;
  logic [B_W-1:0] b_r, b_nxt;
  logic [A_W-1:0] p_r, p_nxt;

  assign done = run_r && (b_r == '0);
  assign prod = p_r;

  // Load on go, then add and shift until the multiplier is exhausted
  always_comb begin
    run_nxt = run_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    p_nxt   = p_r;
    if (!run_r) begin
      if (go) begin
        run_nxt = 1'b1;
        a_nxt   = a_in;
        b_nxt   = b_in;
        p_nxt   = '0;
      end
    end else if (b_r == '0) begin
      run_nxt = 1'b0;
    end else begin
      if (b_r[0]) begin
        p_nxt = p_r + a_r;
      end
      a_nxt = a_r << 1;
      b_nxt = b_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

endmodule

[rtl/mer_ctrl.sv]
// Sequencing controller for the ellipse rasterizer.
// Drives datapath commands and owns both handshakes; uses mer_pkg.
module mer_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_start_req,
  output logic          out_valid,
  input  logic          out_ready,
  input  mer_pkg::sts_t sts,
  output mer_pkg::cmd_t cmd
);

  mer_pkg::state_t state_r, state_nxt;
  logic            nil_r, nil_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;

  // One item in flight; the result slot must be free or draining
  assign in_ready  = (state_r == mer_pkg::S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mer_pkg::S_IDLE: begin
        if (accept) begin
          if (in_start_req) begin
            state_nxt = mer_pkg::S_RXRX;
          end else if (sts.phase == mer_pkg::PH_R1) begin
            state_nxt = mer_pkg::S_CHK;
          end else begin
            state_nxt = mer_pkg::S_EMIT;
          end
        end
      end
      mer_pkg::S_RXRX:   if (sts.mul_done) state_nxt = mer_pkg::S_RYRY;
      mer_pkg::S_RYRY:   if (sts.mul_done) state_nxt = mer_pkg::S_RX2RY;
      mer_pkg::S_RX2RY:  if (sts.mul_done) state_nxt = mer_pkg::S_DEC1;
      mer_pkg::S_DEC1:   state_nxt = mer_pkg::S_CHK;
      mer_pkg::S_CHK: begin
        if (!sts.slope_lt && sts.y_pos) begin
          state_nxt = mer_pkg::S_AA;
        end else begin
          state_nxt = mer_pkg::S_EMIT;
        end
      end
      mer_pkg::S_AA:     if (sts.mul_done) state_nxt = mer_pkg::S_RY2P;
      mer_pkg::S_RY2P:   if (sts.mul_done) state_nxt = mer_pkg::S_BB;
      mer_pkg::S_BB:     if (sts.mul_done) state_nxt = mer_pkg::S_RX2P;
      mer_pkg::S_RX2P:   if (sts.mul_done) state_nxt = mer_pkg::S_RX2RY2;
      mer_pkg::S_RX2RY2: if (sts.mul_done) state_nxt = mer_pkg::S_DEC2;
      mer_pkg::S_DEC2:   state_nxt = mer_pkg::S_EMIT;
      mer_pkg::S_EMIT:   state_nxt = mer_pkg::S_IDLE;
      default:           state_nxt = mer_pkg::S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd          = '0;
    cmd.op       = mer_pkg::OP_NONE;
    cmd.mul_sel  = mer_pkg::MS_RXRX;
    case (state_r)
      mer_pkg::S_IDLE: begin
        if (accept) begin
          if (in_start_req) begin
            cmd.op = mer_pkg::OP_LOAD_START;
          end else if (sts.phase == mer_pkg::PH_R1) begin
            cmd.op = mer_pkg::OP_R1_STEP;
          end else if (sts.phase == mer_pkg::PH_R2) begin
            cmd.op = mer_pkg::OP_R2_STEP;
          end
        end
      end
      mer_pkg::S_RXRX: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = mer_pkg::MS_RXRX;
      end
      mer_pkg::S_RYRY: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = mer_pkg::MS_RYRY;
      end
      mer_pkg::S_RX2RY: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = mer_pkg::MS_RX2RY;
      end
      mer_pkg::S_DEC1: cmd.op = mer_pkg::OP_DEC1;
      mer_pkg::S_CHK: begin
        if (sts.slope_lt) begin
          cmd.op = mer_pkg::OP_SET_R1;
        end else if (!sts.y_pos) begin
          cmd.op = mer_pkg::OP_SET_DONE;
        end
      end
      mer_pkg::S_AA: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = mer_pkg::MS_AA;
      end
      mer_pkg::S_RY2P: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = mer_pkg::MS_RY2P;
      end
      mer_pkg::S_BB: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = mer_pkg::MS_BB;
      end
      mer_pkg::S_RX2P: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = mer_pkg::MS_RX2P;
      end
      mer_pkg::S_RX2RY2: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = mer_pkg::MS_RX2RY2;
      end
      mer_pkg::S_DEC2: cmd.op = mer_pkg::OP_DEC2;
      mer_pkg::S_EMIT: begin
        cmd.emit     = 1'b1;
        cmd.emit_nil = nil_r;
      end
      default: cmd.op = mer_pkg::OP_NONE;
    endcase
  end

  // An advance after completion produces an empty item
  always_comb begin
    nil_nxt = nil_r;
    if (accept) begin
      nil_nxt = !in_start_req && (sts.phase == mer_pkg::PH_DONE);
    end
  end

  // Result slot occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mer_pkg::S_IDLE;
      nil_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nil_r       <= nil_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/mer_datapath.sv]
// Datapath of the ellipse rasterizer: config registers, walk state,
// decision arithmetic, serial multiplier and result register.
// Uses mer_pkg and mer_mul.
module mer_datapath #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mer_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]            cfg_wdata,
  input  mer_pkg::cmd_t                    cmd,
  output mer_pkg::sts_t                    sts,
  output logic signed [mer_pkg::OUT_W-1:0] out_left_x,
  output logic signed [mer_pkg::OUT_W-1:0] out_right_x,
  output logic signed [mer_pkg::OUT_W-1:0] out_top_y,
  output logic signed [mer_pkg::OUT_W-1:0] out_bottom_y,
  output logic                             out_point_valid,
  output logic                             out_last
);

  localparam int N     = COORD_BITS;
  localparam int OFF_W = N + 2;
  localparam int SQ_W  = 2 * N;
  localparam int SL_W  = 3 * N + 3;
  localparam int DEC_W = 4 * N + 8;
  localparam int MB_W  = 2 * N + 4;
  localparam int OW    = mer_pkg::OUT_W;
  localparam int EXT_W = (N + 3 > OW) ? N + 3 : OW;

  // Configuration
  logic [N-1:0] center_x_r, center_x_nxt;
  logic [N-1:0] center_y_r, center_y_nxt;
  logic [N-1:0] radius_x_r, radius_x_nxt;
  logic [N-1:0] radius_y_r, radius_y_nxt;

  // Walk state
  logic signed [OFF_W-1:0] off_x_r, off_x_nxt;
  logic signed [OFF_W-1:0] off_y_r, off_y_nxt;
  logic signed [SL_W-1:0]  sx_r, sx_nxt;
  logic signed [SL_W-1:0]  sy_r, sy_nxt;
  logic signed [DEC_W-1:0] dec_r, dec_nxt;
  logic signed [DEC_W-1:0] acc_r, acc_nxt;
  logic [DEC_W-1:0]        tmp_r, tmp_nxt;
  logic [SQ_W-1:0]         rx2_r, rx2_nxt;
  logic [SQ_W-1:0]         ry2_r, ry2_nxt;
  mer_pkg::phase_t         phase_r, phase_nxt;

  // Result register
  logic signed [OW-1:0] lx_r, lx_nxt, rx_r, rx_nxt, ty_r, ty_nxt, by_r, by_nxt;
  logic                 pv_r, pv_nxt, last_r, last_nxt;

  // Derived terms
  logic signed [SL_W-1:0]  rx2_sl, ry2_sl, sx_inc, sy_dec;
  logic signed [DEC_W-1:0] rx2_dc, ry2_dc, sx_inc_dc, sy_dec_dc, prod_s, q1;
  logic [OFF_W-1:0]        aval, bval;
  logic                    dec_neg, dec_pos, y_le1;
  logic signed [EXT_W-1:0] cx_e, cy_e, ox_e, oy_e;
  logic signed [EXT_W-1:0] lx_e, rx_e, ty_e, by_e;

  // Multiplier port
  logic [DEC_W-1:0] mul_a, prod;
  logic [MB_W-1:0]  mul_b;
  logic             mul_done;

  // Quarter-unit value to integer, truncated toward zero
  function automatic logic signed [DEC_W-1:0] trunc4(input logic signed [DEC_W-1:0] q);
    logic signed [DEC_W-1:0] adj;
    adj = q + (q[DEC_W-1] ? DEC_W'(3) : DEC_W'(0));
    return adj >>> 2;
  endfunction

  assign rx2_sl    = $signed(SL_W'(rx2_r));
  assign ry2_sl    = $signed(SL_W'(ry2_r));
  assign rx2_dc    = $signed(DEC_W'(rx2_r));
  assign ry2_dc    = $signed(DEC_W'(ry2_r));
  assign sx_inc    = sx_r + (ry2_sl <<< 1);
  assign sy_dec    = sy_r - (rx2_sl <<< 1);
  assign sx_inc_dc = DEC_W'(sx_inc);
  assign sy_dec_dc = DEC_W'(sy_dec);
  assign prod_s    = $signed(prod);
  assign q1        = (ry2_dc <<< 2) + rx2_dc + DEC_W'(2) - ($signed(tmp_r) <<< 2);

  assign dec_neg = dec_r[DEC_W-1];
  assign dec_pos = !dec_r[DEC_W-1] && (dec_r != '0);
  assign y_le1   = off_y_r[OFF_W-1] || (off_y_r == OFF_W'(0)) || (off_y_r == OFF_W'(1));

  // 2x+1 and y-1 for the region-2 decision
  assign aval = {off_x_r[OFF_W-2:0], 1'b1};
  assign bval = off_y_r - OFF_W'(1);

  // Status
  assign sts.phase    = phase_r;
  assign sts.slope_lt = sx_r < sy_r;
  assign sts.y_pos    = !off_y_r[OFF_W-1] && (off_y_r != '0);
  assign sts.mul_done = mul_done;

  // Multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      mer_pkg::MS_RXRX: begin
        mul_a = DEC_W'(radius_x_r);
        mul_b = MB_W'(radius_x_r);
      end
      mer_pkg::MS_RYRY: begin
        mul_a = DEC_W'(radius_y_r);
        mul_b = MB_W'(radius_y_r);
      end
      mer_pkg::MS_RX2RY: begin
        mul_a = DEC_W'(rx2_r);
        mul_b = MB_W'(radius_y_r);
      end
      mer_pkg::MS_AA: begin
        mul_a = DEC_W'(aval);
        mul_b = MB_W'(aval);
      end
      mer_pkg::MS_RY2P: begin
        mul_a = DEC_W'(ry2_r);
        mul_b = tmp_r[MB_W-1:0];
      end
      mer_pkg::MS_BB: begin
        mul_a = DEC_W'(bval);
        mul_b = MB_W'(bval);
      end
      mer_pkg::MS_RX2P: begin
        mul_a = DEC_W'(rx2_r);
        mul_b = tmp_r[MB_W-1:0];
      end
      mer_pkg::MS_RX2RY2: begin
        mul_a = DEC_W'(rx2_r);
        mul_b = MB_W'(ry2_r);
      end
      default: mul_a = '0;
    endcase
  end

  mer_mul #(
    .A_W (DEC_W),
    .B_W (MB_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.mul_go),
    .a_in  (mul_a),
    .b_in  (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  // Configuration writes; unknown indexes are dropped
  always_comb begin
    center_x_nxt = center_x_r;
    center_y_nxt = center_y_r;
    radius_x_nxt = radius_x_r;
    radius_y_nxt = radius_y_r;
    if (cfg_we) begin
      case (cfg_index)
        mer_pkg::REG_CENTER_X: center_x_nxt = cfg_wdata;
        mer_pkg::REG_CENTER_Y: center_y_nxt = cfg_wdata;
        mer_pkg::REG_RADIUS_X: radius_x_nxt = cfg_wdata;
        mer_pkg::REG_RADIUS_Y: radius_y_nxt = cfg_wdata;
        default:               center_x_nxt = center_x_r;
      endcase
    end
  end

  // Walk state updates
  always_comb begin
    off_x_nxt = off_x_r;
    off_y_nxt = off_y_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    dec_nxt   = dec_r;
    acc_nxt   = acc_r;
    tmp_nxt   = tmp_r;
    rx2_nxt   = rx2_r;
    ry2_nxt   = ry2_r;
    phase_nxt = phase_r;

    case (cmd.op)
      mer_pkg::OP_LOAD_START: begin
        off_x_nxt = '0;
        off_y_nxt = $signed(OFF_W'(radius_y_r));
        sx_nxt    = '0;
        // no region holds until the start sequence settles it
        phase_nxt = mer_pkg::PH_DONE;
      end
      mer_pkg::OP_R1_STEP: begin
        off_x_nxt = off_x_r + OFF_W'(1);
        sx_nxt    = sx_inc;
        if (dec_neg) begin
          dec_nxt = dec_r + ry2_dc + sx_inc_dc;
        end else begin
          off_y_nxt = off_y_r - OFF_W'(1);
          sy_nxt    = sy_dec;
          dec_nxt   = dec_r + ry2_dc + sx_inc_dc - sy_dec_dc;
        end
      end
      mer_pkg::OP_R2_STEP: begin
        off_y_nxt = off_y_r - OFF_W'(1);
        sy_nxt    = sy_dec;
        if (dec_pos) begin
          dec_nxt = dec_r + rx2_dc - sy_dec_dc;
        end else begin
          off_x_nxt = off_x_r + OFF_W'(1);
          sx_nxt    = sx_inc;
          dec_nxt   = dec_r + rx2_dc - sy_dec_dc + sx_inc_dc;
        end
        if (y_le1) begin
          phase_nxt = mer_pkg::PH_DONE;
        end
      end
      mer_pkg::OP_DEC1:     dec_nxt = trunc4(q1);
      mer_pkg::OP_DEC2: begin
        dec_nxt   = trunc4(acc_r);
        phase_nxt = mer_pkg::PH_R2;
      end
      mer_pkg::OP_SET_R1:   phase_nxt = mer_pkg::PH_R1;
      mer_pkg::OP_SET_DONE: phase_nxt = mer_pkg::PH_DONE;
      default:              phase_nxt = phase_r;
    endcase

    // Product write-back at the end of each multiply
    if (mul_done) begin
      case (cmd.mul_sel)
        mer_pkg::MS_RXRX:   rx2_nxt = prod[SQ_W-1:0];
        mer_pkg::MS_RYRY:   ry2_nxt = prod[SQ_W-1:0];
        mer_pkg::MS_RX2RY: begin
          sy_nxt  = $signed(SL_W'(prod)) <<< 1;
          tmp_nxt = prod;
        end
        mer_pkg::MS_AA:     tmp_nxt = prod;
        mer_pkg::MS_RY2P:   acc_nxt = prod_s;
        mer_pkg::MS_BB:     tmp_nxt = prod;
        mer_pkg::MS_RX2P:   acc_nxt = acc_r + (prod_s <<< 2);
        mer_pkg::MS_RX2RY2: acc_nxt = acc_r - (prod_s <<< 2);
        default:            tmp_nxt = tmp_r;
      endcase
    end
  end

  // Mirrored points, wrapped to the result width
  assign cx_e = $signed(EXT_W'(center_x_r));
  assign cy_e = $signed(EXT_W'(center_y_r));
  assign ox_e = EXT_W'(off_x_r);
  assign oy_e = EXT_W'(off_y_r);
  assign lx_e = cx_e - ox_e;
  assign rx_e = cx_e + ox_e;
  assign ty_e = cy_e - oy_e;
  assign by_e = cy_e + oy_e;

  always_comb begin
    lx_nxt   = lx_r;
    rx_nxt   = rx_r;
    ty_nxt   = ty_r;
    by_nxt   = by_r;
    pv_nxt   = pv_r;
    last_nxt = last_r;
    if (cmd.emit) begin
      if (cmd.emit_nil) begin
        lx_nxt   = '0;
        rx_nxt   = '0;
        ty_nxt   = '0;
        by_nxt   = '0;
        pv_nxt   = 1'b0;
        last_nxt = 1'b0;
      end else begin
        lx_nxt   = lx_e[OW-1:0];
        rx_nxt   = rx_e[OW-1:0];
        ty_nxt   = ty_e[OW-1:0];
        by_nxt   = by_e[OW-1:0];
        pv_nxt   = 1'b1;
        last_nxt = (phase_r == mer_pkg::PH_DONE);
      end
    end
  end

  assign out_left_x      = lx_r;
  assign out_right_x     = rx_r;
  assign out_top_y       = ty_r;
  assign out_bottom_y    = by_r;
  assign out_point_valid = pv_r;
  assign out_last        = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_x_r <= '0;
      radius_y_r <= '0;
      phase_r    <= mer_pkg::PH_DONE;
    end else begin
      center_x_r <= center_x_nxt;
      center_y_r <= center_y_nxt;
      radius_x_r <= radius_x_nxt;
      radius_y_r <= radius_y_nxt;
      phase_r    <= phase_nxt;
    end
    off_x_r <= off_x_nxt;
    off_y_r <= off_y_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    dec_r   <= dec_nxt;
    acc_r   <= acc_nxt;
    tmp_r   <= tmp_nxt;
    rx2_r   <= rx2_nxt;
    ry2_r   <= ry2_nxt;
    lx_r    <= lx_nxt;
    rx_r    <= rx_nxt;
    ty_r    <= ty_nxt;
    by_r    <= by_nxt;
    pv_r    <= pv_nxt;
    last_r  <= last_nxt;
  end

endmodule

[rtl/midpoint_ellipse_rasterizer.sv]
// Midpoint ellipse rasterizer, top level. One item at a time: the EMIT state writes the result
// register; it is entered straight after acceptance for a region-2 step or an advance after completion,
// and through CHK for a region-1 step; the next item is taken once that result drains. A start adds 3
// serial multiplies and a DEC1 step, a region-1 to region-2 switch 5 multiplies and a DEC2 step; the
// shift-and-add multiplier stops once its multiplier operand (at most 2*COORD_BITS+4 bits) is used up.
// Synchronous active-low reset clears config and control and leaves the walk completed.
module midpoint_ellipse_rasterizer #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mer_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]            cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_start_req,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [mer_pkg::OUT_W-1:0] out_left_x,
  output logic signed [mer_pkg::OUT_W-1:0] out_right_x,
  output logic signed [mer_pkg::OUT_W-1:0] out_top_y,
  output logic signed [mer_pkg::OUT_W-1:0] out_bottom_y,
  output logic                             out_point_valid,
  output logic                             out_last
);

  mer_pkg::cmd_t cmd;
  mer_pkg::sts_t sts;

  mer_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_start_req (in_start_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  mer_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .sts             (sts),
    .out_left_x      (out_left_x),
    .out_right_x     (out_right_x),
    .out_top_y       (out_top_y),
    .out_bottom_y    (out_bottom_y),
    .out_point_valid (out_point_valid),
    .out_last        (out_last)
  );

  // A new result never lands on one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_valid)
    else $error("result register overwritten");

  // The multiplier only finishes while a multiply is being sequenced
  a_mul_owned: assert property (@(posedge clk) disable iff (!rst_n)
    sts.mul_done |-> cmd.mul_go)
    else $error("multiply finished outside a multiply state");

  // Region 2 is only ever held with a positive y offset
  a_r2_y_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (sts.phase == mer_pkg::PH_R2) |-> sts.y_pos)
    else $error("region 2 with non-positive y offset");

  // The final point set is always a real one
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> out_point_valid)
    else $error("last flag on an empty item");

endmodule

[dv/tb_midpoint_ellipse_rasterizer.sv]
// Self-checking testbench for the midpoint ellipse rasterizer: random and directed
// walks, a cycle-free predictor of the point sets and a field-by-field scoreboard.
// Depends on mer_pkg and midpoint_ellipse_rasterizer.
module tb_midpoint_ellipse_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB   = mer_pkg::COORD_BITS_DEF;
  localparam int OW   = mer_pkg::OUT_W;
  localparam int IDXW = mer_pkg::CFG_IDX_W;

  // One result item: the four mirrored coordinates and the flags
  typedef struct {
    logic signed [OW-1:0] left_x;
    logic signed [OW-1:0] right_x;
    logic signed [OW-1:0] top_y;
    logic signed [OW-1:0] bottom_y;
    logic                 point_valid;
    logic                 last;
  } point_set_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [IDXW-1:0]      cfg_index = '0;
  logic [CB-1:0]        cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_start_req = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [OW-1:0] out_left_x;
  logic signed [OW-1:0] out_right_x;
  logic signed [OW-1:0] out_top_y;
  logic signed [OW-1:0] out_bottom_y;
  logic                 out_point_valid;
  logic                 out_last;

  // Stimulus and scoreboard
  logic       start_cmds[$];
  point_set_t pending_points[$];
  int         items_sent = 0;
  int         results_seen = 0;
  int         mismatches = 0;
  bit         send_idle_en = 1'b1;
  bit         rcv_idle_en = 1'b1;
  int         send_gap = 0;
  int         rcv_gap = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  // Predictor copy of the registers and the walk state
  logic [CB-1:0]       ctr_x = '0;
  logic [CB-1:0]       ctr_y = '0;
  logic [CB-1:0]       rad_x = '0;
  logic [CB-1:0]       rad_y = '0;
  logic [10:0]         ofs_x = '0;
  logic [10:0]         ofs_y = '0;
  logic signed [33:0]  slope_x = '0;
  logic signed [33:0]  slope_y = '0;
  logic signed [47:0]  dec_val = '0;
  logic [19:0]         sq_rx = '0;
  logic [19:0]         sq_ry = '0;
  mer_pkg::phase_t     walk_ph = mer_pkg::PH_DONE;

  midpoint_ellipse_rasterizer #(.COORD_BITS(CB)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_req   (in_start_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_left_x     (out_left_x),
    .out_right_x    (out_right_x),
    .out_top_y      (out_top_y),
    .out_bottom_y   (out_bottom_y),
    .out_point_valid(out_point_valid),
    .out_last       (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [OW-1:0] wrap_coord(longint v);
    return v[OW-1:0];
  endfunction

  // Advance the walk by one item and work out the point set it yields
  task automatic trace_step(input logic start, output point_set_t ps);
    longint rx, ry, rx2, ry2, ox, oy, sx, sy, d, a, b;
    logic   live;
    logic   leave_chk;
    rx2 = longint'(sq_rx);
    ry2 = longint'(sq_ry);
    ox = longint'(ofs_x);
    oy = longint'(ofs_y);
    sx = longint'(slope_x);
    sy = longint'(slope_y);
    d = longint'(dec_val);
    live = start || (walk_ph != mer_pkg::PH_DONE);
    leave_chk = 1'b0;
    ps = '{default: '0};
    if (start) begin
      rx = longint'(rad_x);
      ry = longint'(rad_y);
      rx2 = rx * rx;
      ry2 = ry * ry;
      ox = 0;
      oy = ry;
      sx = 0;
      sy = 2 * rx2 * ry;
      // quarter-unit form, truncated toward zero
      d = (4 * ry2 - 4 * rx2 * ry + rx2 + 2) / 4;
      leave_chk = 1'b1;
    end else if (walk_ph == mer_pkg::PH_R1) begin
      ox++;
      sx += 2 * ry2;
      if (d < 0) begin
        d += ry2 + sx;
      end else begin
        oy--;
        sy -= 2 * rx2;
        d += ry2 + sx - sy;
      end
      leave_chk = 1'b1;
    end else if (walk_ph == mer_pkg::PH_R2) begin
      oy--;
      sy -= 2 * rx2;
      if (d > 0) begin
        d += rx2 - sy;
      end else begin
        ox++;
        sx += 2 * ry2;
        d += rx2 - sy + sx;
      end
      if (oy <= 0) walk_ph = mer_pkg::PH_DONE;
    end
    // region 1 ends once the slope terms cross; region 2 only if y is left
    if (leave_chk) begin
      if (sx < sy) begin
        walk_ph = mer_pkg::PH_R1;
      end else if (oy > 0) begin
        a = 2 * ox + 1;
        b = oy - 1;
        d = (ry2 * a * a + 4 * rx2 * b * b - 4 * rx2 * ry2) / 4;
        walk_ph = mer_pkg::PH_R2;
      end else begin
        walk_ph = mer_pkg::PH_DONE;
      end
    end
    if (live) begin
      ps.left_x = wrap_coord(longint'(ctr_x) - ox);
      ps.right_x = wrap_coord(longint'(ctr_x) + ox);
      ps.top_y = wrap_coord(longint'(ctr_y) - oy);
      ps.bottom_y = wrap_coord(longint'(ctr_y) + oy);
      ps.point_valid = 1'b1;
      ps.last = (walk_ph == mer_pkg::PH_DONE);
    end
    ofs_x = ox[10:0];
    ofs_y = oy[10:0];
    slope_x = sx[33:0];
    slope_y = sy[33:0];
    dec_val = d[47:0];
    sq_rx = rx2[19:0];
    sq_ry = ry2[19:0];
  endtask

  function automatic void check_field(string fname, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
    end
  endfunction

  // Input driver: offers queued items, predicts each one as it is accepted
  always @(posedge clk) begin : sender
    logic       nxt_valid;
    logic       nxt_start;
    point_set_t ps;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      nxt_valid = in_valid;
      nxt_start = in_start_req;
      if (in_valid && in_ready) begin
        trace_step(in_start_req, ps);
        pending_points.push_back(ps);
        nxt_valid = 1'b0;
        if (send_idle_en) send_gap = gap_len();
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (start_cmds.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_start = start_cmds.pop_front();
        end
      end
      in_valid <= nxt_valid;
      in_start_req <= nxt_start;
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk) begin : receiver
    point_set_t want;
    logic       nxt_ready;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_points.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected item: expected none, actual %0d %0d %0d %0d pv=%0d last=%0d",
                   $time, out_left_x, out_right_x, out_top_y, out_bottom_y,
                   out_point_valid, out_last);
        end else begin
          want = pending_points.pop_front();
          check_field("left_x", longint'(want.left_x), longint'(out_left_x));
          check_field("right_x", longint'(want.right_x), longint'(out_right_x));
          check_field("top_y", longint'(want.top_y), longint'(out_top_y));
          check_field("bottom_y", longint'(want.bottom_y), longint'(out_bottom_y));
          check_field("point_valid", longint'(want.point_valid), longint'(out_point_valid));
          check_field("last", longint'(want.last), longint'(out_last));
        end
      end
      // one long hold-off while the sender still has items to offer
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (!hold_done && results_seen >= 300 && start_cmds.size() > 8) begin
        hold_done = 1'b1;
        hold_left = 500;
        nxt_ready = 1'b0;
      end else if (rcv_gap > 0) begin
        rcv_gap--;
        nxt_ready = 1'b0;
      end else if (rcv_idle_en && $urandom_range(0, 3) == 0) begin
        rcv_gap = gap_len();
        nxt_ready = (rcv_gap == 0);
      end else begin
        nxt_ready = 1'b1;
      end
      out_ready <= nxt_ready;
    end
  end

  task automatic post_advances(int n);
    repeat (n) start_cmds.push_back(1'b0);
    items_sent += n;
  endtask

  task automatic post_walk(int n_adv);
    start_cmds.push_back(1'b1);
    items_sent++;
    post_advances(n_adv);
  endtask

  // Idle means nothing queued, nothing on offer and nothing outstanding
  task automatic settle();
    while (start_cmds.size() != 0 || in_valid || pending_points.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDXW-1:0] idx, logic [CB-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      mer_pkg::REG_CENTER_X: ctr_x = val;
      mer_pkg::REG_CENTER_Y: ctr_y = val;
      mer_pkg::REG_RADIUS_X: rad_x = val;
      mer_pkg::REG_RADIUS_Y: rad_y = val;
      default: ;
    endcase
  endtask

  // Write all four registers in a rotated order, optionally hitting a spare index
  task automatic set_regs(int cx, int cy, int rx, int ry, bit spare);
    logic [IDXW-1:0] idx[4];
    int              val[4];
    int              base;
    idx = '{mer_pkg::REG_CENTER_X, mer_pkg::REG_CENTER_Y,
            mer_pkg::REG_RADIUS_X, mer_pkg::REG_RADIUS_Y};
    val = '{cx, cy, rx, ry};
    base = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++)
      write_reg(idx[(base + k) % 4], CB'(val[(base + k) % 4]));
    // indexes past the last register must leave everything untouched
    if (spare)
      write_reg(IDXW'(mer_pkg::REG_RADIUS_Y + $urandom_range(1, 4)),
                CB'($urandom_range(0, 1023)));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_centre();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 1023;
    return $urandom_range(0, 1023);
  endfunction

  function automatic int pick_radius();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 20);
    if (r < 90) return $urandom_range(21, 100);
    if (r < 97) return $urandom_range(101, 1022);
    return 1023;
  endfunction

  initial begin : stimulus
    int cx, cy, rx, ry, span, n_adv;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // advances straight after reset, then the zero-size ellipse
    post_advances(2);
    post_walk(1);
    settle();
    // largest radii about the origin: coordinates go negative
    set_regs(0, 0, 1023, 1023, 1'b1);
    post_walk(4);
    settle();
    // new centre mid-walk, then a flat ellipse whose top point is the last
    set_regs(1023, 1023, 2, 0, 1'b1);
    post_advances(2);
    post_walk(1);
    settle();
    // zero horizontal radius: straight into region 2
    set_regs(512, 300, 0, 3, 1'b0);
    post_walk(4);
    settle();
    // small full walk through both regions and past the end
    set_regs(700, 5, 3, 2, 1'b0);
    post_walk(6);

    // random walks, mostly complete, some cut short or preceded by stray advances
    while (items_sent < 1250) begin
      settle();
      send_idle_en = ($urandom_range(0, 3) != 0);
      rcv_idle_en = ($urandom_range(0, 3) != 0);
      cx = pick_centre();
      cy = pick_centre();
      rx = pick_radius();
      ry = pick_radius();
      set_regs(cx, cy, rx, ry, $urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) post_advances($urandom_range(1, 6));
      repeat ($urandom_range(1, 3)) begin
        span = rx + ry + 2;
        if (span > 150) n_adv = $urandom_range(10, 150);
        else if ($urandom_range(0, 4) != 0) n_adv = span;
        else n_adv = $urandom_range(0, span);
        post_walk(n_adv);
      end
    end

    settle();
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #16_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
